// ----- hw/rtl/ole_pkg.sv -----
// ----------------------------------------------------------------------------
// ole_pkg - shared types and constants for the ordered list engine
// Operation and status codes, sequencer states and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

   localparam int VALUE_W    = 32;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 6;
   localparam int LEN_W      = 6;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT  = 3'd0,
      KIND_SEARCH  = 3'd1,
      KIND_DELETE  = 3'd2,
      KIND_REVERSE = 3'd3,
      KIND_DUMP    = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_NOTFOUND = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_INS_HEAD,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DEL_RD,
      S_DEL_WR,
      S_REV_RDLO,
      S_REV_RDHI,
      S_REV_WRLO,
      S_REV_WRHI,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_EMIT
   } state_type;

   // result word, status in the lowest bits, padded to whole bytes
   typedef struct packed {
      logic [1:0]         pad;
      logic [LEN_W-1:0]   length;
      logic [VALUE_W-1:0] element;
      logic [POS_W-1:0]   position;
      status_type         status;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ole_store.sv -----
// ----------------------------------------------------------------------------
// ole_store - element store of the ordered list engine
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_store #(
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [ole_pkg::VALUE_W-1:0] rd_data,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [ole_pkg::VALUE_W-1:0] wr_data
);
   import ole_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_list_engine_core.sv -----
// Insert, search, delete, reverse and dump walk the store element by element
// (reverse by swapped pair) before the result word, which a stall on the
// result side can hold back.
// Throughput: one word at a time; req_tready is high only while idle, from the
// cycle after the last result word of an item is loaded.
// Reset (synchronous, high) empties the list and drops any pending result; store not cleared.
// ----------------------------------------------------------------------------
// ordered_list_engine_core - sequenced ordered list of signed 32-bit values
// Insert at front, search, delete first match, reverse and dump, all walked
// through a store with one read and one write port under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_core #(
   parameter int CAPACITY = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [ole_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] value
   input  wire logic [ole_pkg::KIND_W-1:0]     req_tuser,  // [2:0] kind
   // result channel
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [1:0] status, [7:2] position, [39:8] element, [45:40] length, [47:46] 0
   output logic      [ole_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import ole_pkg::*;

   localparam int AW = $clog2(CAPACITY);      // store address
   localparam int CW = $clog2(CAPACITY + 1);  // counts 0..CAPACITY

   // sequencer state
   state_type          state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;      // list length
   logic [CW-1:0]      idx_ff, idx_in;        // walking index (lo end on reverse)
   logic [CW-1:0]      hi_ff, hi_in;          // hi end on reverse
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0] tmp_ff, tmp_in;        // swap holding register
   logic               del_ff, del_in;        // search walk belongs to a delete
   status_type         pend_status_ff, pend_status_in;
   logic [POS_W-1:0]   pend_pos_ff, pend_pos_in;

   // output register
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;
   logic               rsp_last_ff;
   logic               out_load;
   rsp_word_type       out_word;
   logic               out_last;
   logic               out_free;

   // store port
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;

   // step logic for the walking index, shared by all walks: index up/down
   logic [CW-1:0]      idx_inc;
   logic [CW-1:0]      idx_dec;

   assign idx_inc  = idx_ff + 1'b1;
   assign idx_dec  = idx_ff - 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;

   ole_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      hi_ff          <= hi_in;
      key_ff         <= key_in;
      tmp_ff         <= tmp_in;
      del_ff         <= del_in;
      pend_status_ff <= pend_status_in;
      pend_pos_ff    <= pend_pos_in;
   end

   // next state and datapath control
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      hi_in          = hi_ff;
      key_in         = key_ff;
      tmp_in         = tmp_ff;
      del_in         = del_ff;
      pend_status_in = pend_status_ff;
      pend_pos_in    = pend_pos_ff;

      req_tready = (state_ff == S_IDLE);

      rd_en   = 1'b0;
      rd_addr = idx_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;

      out_load          = 1'b0;
      out_last          = 1'b1;
      out_word.pad      = '0;
      out_word.length   = LEN_W'(fill_ff);
      out_word.element  = '0;
      out_word.position = pend_pos_ff;
      out_word.status   = pend_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in         = req_tdata;
               del_in         = 1'b0;
               idx_in         = '0;
               pend_pos_in    = '0;
               pend_status_in = STAT_OK;
               case (kind_type'(req_tuser))
                  KIND_INSERT: begin
                     if (fill_ff == CW'(CAPACITY)) begin
                        pend_status_in = STAT_FULL;
                        state_in       = S_EMIT;
                     end else begin
                        idx_in   = fill_ff;
                        state_in = (fill_ff == '0) ? S_INS_HEAD : S_INS_RD;
                     end
                  end
                  KIND_SEARCH, KIND_DELETE: begin
                     del_in = (kind_type'(req_tuser) == KIND_DELETE);
                     if (fill_ff == '0) begin
                        pend_status_in = STAT_NOTFOUND;
                        state_in       = S_EMIT;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  KIND_REVERSE: begin
                     if (fill_ff > CW'(1)) begin
                        hi_in    = fill_ff - 1'b1;
                        state_in = S_REV_RDLO;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  KIND_DUMP: begin
                     if (fill_ff == '0) begin
                        pend_status_in = STAT_EMPTY;
                        state_in       = S_EMIT;
                     end else begin
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         // insert: move each element up one place, top first
         S_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_dec[AW-1:0];
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            wr_data  = rd_data;
            idx_in   = idx_dec;
            state_in = (idx_dec == '0) ? S_INS_HEAD : S_INS_RD;
         end
         S_INS_HEAD: begin
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_data        = key_ff;
            fill_in        = fill_ff + 1'b1;
            pend_status_in = STAT_OK;
            state_in       = S_EMIT;
         end

         // search walk, shared with delete
         S_SRCH_RD: begin
            rd_en    = 1'b1;
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (rd_data == key_ff) begin
               if (del_ff) begin
                  state_in = S_DEL_RD;
               end else begin
                  pend_status_in = STAT_OK;
                  pend_pos_in    = POS_W'(idx_inc);
                  state_in       = S_EMIT;
               end
            end else begin
               idx_in = idx_inc;
               if (idx_inc == fill_ff) begin
                  pend_status_in = STAT_NOTFOUND;
                  state_in       = S_EMIT;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end
         end

         // delete: close the gap, bottom first
         S_DEL_RD: begin
            if (idx_inc == fill_ff) begin
               fill_in        = fill_ff - 1'b1;
               pend_status_in = STAT_OK;
               state_in       = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_inc[AW-1:0];
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_inc;
            state_in = S_DEL_RD;
         end

         // reverse: swap the two ends, moving inwards
         S_REV_RDLO: begin
            rd_en    = 1'b1;
            state_in = S_REV_RDHI;
         end
         S_REV_RDHI: begin
            tmp_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = hi_ff[AW-1:0];
            state_in = S_REV_WRLO;
         end
         S_REV_WRLO: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            state_in = S_REV_WRHI;
         end
         S_REV_WRHI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff[AW-1:0];
            wr_data = tmp_ff;
            idx_in  = idx_inc;
            hi_in   = hi_ff - 1'b1;
            if (idx_inc < hi_ff - 1'b1) begin
               state_in = S_REV_RDLO;
            end else begin
               pend_status_in = STAT_OK;
               state_in       = S_EMIT;
            end
         end

         // dump: one word per element, last one marked
         S_DUMP_RD: begin
            rd_en    = 1'b1;
            state_in = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            out_word.status   = STAT_OK;
            out_word.position = POS_W'(idx_inc);
            out_word.element  = rd_data;
            out_last          = (idx_inc == fill_ff);
            if (out_free) begin
               out_load = 1'b1;
               if (idx_inc == fill_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_DUMP_RD;
               end
            end
         end

         // single-word result, held until the output register is free
         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff <= out_word;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

   // length never goes past the store size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("list length beyond capacity");

   // length moves by at most one per operation
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(fill_ff) |-> (fill_ff == $past(fill_ff) + 1'b1 ||
                             fill_ff == $past(fill_ff) - 1'b1))
      else $error("list length jumped");

   // walking index stays at or below the list length while the store is in use
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_EMIT) |-> idx_ff <= fill_ff)
      else $error("walk index beyond list length");

   // a result word is only loaded when the output register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !out_load)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- bench/tb_ordered_list_engine_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_core - self-checking bench for the ordered list engine
// Request words go in through named tests. Each accepted word is run through a
// behavioural copy of the list, which queues the result words it should cause.
// The receive side pops that queue and compares every field of every result.
// ----------------------------------------------------------------------------

module tb_ordered_list_engine_core;
   import ole_pkg::*;

   localparam int CAPACITY        = 32;
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no word moving on either side
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 4 * CAPACITY + 16;
   localparam int RANDOM_WORDS    = 80;

   // kinds with no operation behind them
   localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   typedef struct {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] element;
      logic [LEN_W-1:0]   length;
      logic               last;
   } list_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [31:0] value
   logic [KIND_W-1:0]     req_tuser  = '0;  // [2:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [1:0] status, [7:2] position, [39:8] element, [45:40] length, [47:46] 0
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // shadow copy of the list, front at index 0
   logic [VALUE_W-1:0] shadow_list [CAPACITY];
   int                 shadow_len = 0;
   list_result_type    pending_results [$];

   bit idle_on     = 1'b0;
   int hold_left   = 0;
   int stall_left  = 0;
   int quiet_count = 0;
   int error_count = 0;

   ordered_list_engine_core #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // list behaviour
   // ------------------------------------------------------------------------

   // length field always carries the length after the operation
   function automatic void queue_result(status_type st, int pos, logic [VALUE_W-1:0] elem,
                                        bit fin);
      list_result_type r;
      r.status   = st;
      r.position = POS_W'(pos);
      r.element  = elem;
      r.length   = LEN_W'(shadow_len);
      r.last     = fin;
      pending_results.push_back(r);
   endfunction

   function automatic void apply_list_op(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
      int                 hit;
      int                 lo;
      int                 hi;
      logic [VALUE_W-1:0] held;
      hit = 0;
      for (int i = 0; i < shadow_len; i++)
         if (hit == 0 && shadow_list[i] == value)
            hit = i + 1;
      case (kind)
         KIND_INSERT: begin
            if (shadow_len >= CAPACITY) begin
               queue_result(STAT_FULL, 0, '0, 1'b1);   // dropped, list untouched
            end else begin
               for (int i = shadow_len; i > 0; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[0] = value;
               shadow_len++;
               queue_result(STAT_OK, 0, '0, 1'b1);
            end
         end
         KIND_SEARCH: begin
            queue_result(hit != 0 ? STAT_OK : STAT_NOTFOUND, hit, '0, 1'b1);
         end
         KIND_DELETE: begin
            if (hit == 0) begin
               queue_result(STAT_NOTFOUND, 0, '0, 1'b1);
            end else begin
               for (int i = hit - 1; i + 1 < shadow_len; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_len--;
               queue_result(STAT_OK, 0, '0, 1'b1);
            end
         end
         KIND_REVERSE: begin
            lo = 0;
            hi = shadow_len - 1;
            while (lo < hi) begin
               held            = shadow_list[lo];
               shadow_list[lo] = shadow_list[hi];
               shadow_list[hi] = held;
               lo++;
               hi--;
            end
            queue_result(STAT_OK, 0, '0, 1'b1);
         end
         KIND_DUMP: begin
            if (shadow_len == 0)
               queue_result(STAT_EMPTY, 0, '0, 1'b1);
            else
               for (int i = 0; i < shadow_len; i++)
                  queue_result(STAT_OK, i + 1, shadow_list[i], i == shadow_len - 1);
         end
         default: begin
            queue_result(STAT_OK, 0, '0, 1'b1);     // spare kinds change nothing
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // request side: called just after a rising edge, returns at the edge that
   // took the word, with tvalid still high so a back-to-back word needs no dip
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      apply_list_op(kind, value);
   endtask

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t ns: mismatch on %s, got %0h, wanted %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_result();
      rsp_word_type    got;
      list_result_type want;
      got = rsp_word_type'(rsp_tdata);
      if (pending_results.size() == 0) begin
         report_mismatch("word with nothing pending", rsp_tdata, '0);
         return;
      end
      want = pending_results.pop_front();
      if (got.status   !== want.status)   report_mismatch("status", got.status, want.status);
      if (got.position !== want.position) report_mismatch("position", got.position, want.position);
      if (got.element  !== want.element)  report_mismatch("element", got.element, want.element);
      if (got.length   !== want.length)   report_mismatch("length", got.length, want.length);
      if (rsp_tlast    !== want.last)     report_mismatch("tlast", rsp_tlast, want.last);
      if (got.pad      !== 2'b00)         report_mismatch("pad bits", got.pad, 2'b00);
   endtask

   // random stall per word; a hold-off keeps tready low for its whole stretch
   always @(posedge clock) begin : rsp_side
      int gap;
      if (rsp_tvalid && rsp_tready) begin
         check_result();
         gap = idle_on ? $urandom_range(0, 10) : 0;
         stall_left <= gap;
         rsp_tready <= (gap == 0) && (hold_left == 0);
      end else begin
         if (stall_left != 0)
            stall_left <= stall_left - 1;
         rsp_tready <= (stall_left <= 1) && (hold_left <= 1);
      end
   end

   always @(posedge clock)
      if (hold_left != 0)
         hold_left <= hold_left - 1;

   // no word on either side for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("tb_ordered_list_engine_core: errors");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // small pool for repeats, stored values for hits, the two extremes, else anything
   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)
         return VALUE_W'($urandom_range(0, 7));
      if (roll < 70 && shadow_len > 0)
         return shadow_list[$urandom_range(0, shadow_len - 1)];
      if (roll < 75)
         return roll[0] ? 32'h8000_0000 : 32'h7fff_ffff;
      return $urandom;
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(bit growing);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < (growing ? 45 : 15)) return KIND_INSERT;
      if (roll < 60)                  return KIND_SEARCH;
      if (roll < 78)                  return KIND_DELETE;
      if (roll < 85)                  return KIND_REVERSE;
      if (roll < 95)                  return KIND_DUMP;
      case ($urandom_range(0, 2))
         0:       return KIND_SPARE_5;
         1:       return KIND_SPARE_6;
         default: return KIND_SPARE_7;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // every operation on an empty list, then a single element
   task automatic test_empty_list();
      send_word(KIND_DUMP, '0);
      send_word(KIND_SEARCH, '0);
      send_word(KIND_DELETE, '0);
      send_word(KIND_REVERSE, '0);
      send_word(KIND_SPARE_5, $urandom);
      send_word(KIND_SPARE_6, $urandom);
      send_word(KIND_SPARE_7, $urandom);
      send_word(KIND_INSERT, 32'd42);
      send_word(KIND_REVERSE, '0);
      send_word(KIND_DUMP, '0);
      send_word(KIND_DELETE, 32'd42);
   endtask

   // extreme values, a duplicate, hits and misses, reverse of an even length
   task automatic test_extremes();
      send_word(KIND_INSERT, 32'h8000_0000);
      send_word(KIND_INSERT, 32'h7fff_ffff);
      send_word(KIND_INSERT, 32'h0000_0000);
      send_word(KIND_INSERT, 32'hffff_ffff);
      send_word(KIND_INSERT, 32'h7fff_ffff);
      send_word(KIND_SEARCH, 32'h7fff_ffff);   // first match from the front
      send_word(KIND_SEARCH, 32'h8000_0000);   // at the back
      send_word(KIND_SEARCH, 32'h1234_5678);
      send_word(KIND_DELETE, 32'h7fff_ffff);
      send_word(KIND_REVERSE, '0);
      send_word(KIND_DUMP, '0);
      send_word(KIND_DELETE, 32'h8000_0000);
      send_word(KIND_DELETE, 32'h5555_5555);
      send_word(KIND_DUMP, '0);
   endtask

   // fill to capacity, inserts dropped when full, longest dump
   task automatic test_full_list();
      idle_on <= 1'b1;
      while (shadow_len < CAPACITY)
         send_word(KIND_INSERT, $urandom);
      send_word(KIND_INSERT, $urandom);
      send_word(KIND_INSERT, 32'h8000_0000);
      send_word(KIND_DUMP, '0);
      send_word(KIND_REVERSE, '0);
      send_word(KIND_DUMP, '0);
      send_word(KIND_SEARCH, shadow_list[CAPACITY-1]);
      send_word(KIND_DELETE, shadow_list[CAPACITY-1]);
      send_word(KIND_INSERT, $urandom);
      send_word(KIND_INSERT, $urandom);
   endtask

   // receiver holds off while full dumps keep coming, so the request side stalls
   task automatic test_backpressure();
      idle_on   <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      send_word(KIND_DUMP, '0);
      send_word(KIND_DUMP, '0);
      send_word(KIND_SEARCH, pick_value());
      send_word(KIND_DUMP, '0);
   endtask

   // first half leans to inserts, second half less so, then deletes drain the list; idling toggles in blocks
   task automatic test_random();
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0)
            idle_on <= (n % 80 == 0);
         send_word(pick_kind(n < RANDOM_WORDS / 2), pick_value());
      end
      while (shadow_len != 0)
         send_word(KIND_DELETE, shadow_list[$urandom_range(0, shadow_len - 1)]);
      send_word(KIND_DUMP, '0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_extremes();
      test_full_list();
      test_backpressure();
      test_random();

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("tb_ordered_list_engine_core: clean");
      else
         $display("tb_ordered_list_engine_core: errors");
      $finish;
   end

endmodule
